FILE: src/gcbce_pkg.sv
package gcbce_pkg;

	// Cache geometry; both counts are powers of two.
	localparam int BUCKETS     = 512;
	localparam int MAX_ENTRIES = 4096;
	localparam int SW          = $clog2(MAX_ENTRIES);
	localparam int NW          = SW + 1;
	localparam int BW          = $clog2(BUCKETS);
	localparam int CLR_N       = (MAX_ENTRIES > BUCKETS) ? MAX_ENTRIES : BUCKETS;
	localparam int CW          = $clog2(CLR_N);

	localparam logic [NW-1:0] NIL        = NW'(MAX_ENTRIES);
	localparam logic [31:0]   HASH_MIX   = 32'h9e3779b9;
	localparam logic [31:0]   HASH_MUL   = 32'd2654435761;
	localparam logic [23:0]   CHARGE_MAX = 24'hFFFFFF;
	localparam logic [31:0]   BUDGET_RST = 32'd8388608;
	localparam logic [3:0]    FACES_RST  = 4'd1;

	// Command codes of an input beat.
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_CHARGE = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;

	// Register indexes.
	localparam logic REG_FACES  = 1'b0;
	localparam logic REG_BUDGET = 1'b1;

	// Datapath operation issued by the controller each cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LATCH,
		OP_DECODE,
		OP_HEAD,
		OP_CMP,
		OP_EVCHK,
		OP_EVSCAN,
		OP_EVWALK,
		OP_ALLOC,
		OP_ALLOC_RD,
		OP_INSERT,
		OP_CHARGE,
		OP_LOAD_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] cmd;
		logic       face_refused;
		logic       head_empty;
		logic       hit;
		logic       next_nil;
		logic       ev_need;
		logic       scan_empty;
		logic       scan_last;
		logic       full;
		logic       free_avail;
		logic       fresh_avail;
		logic       out_busy;
	} dp_stat_t;

endpackage

FILE: src/glyph_cache_bucket_clock_evict_top.sv
// Each beat is latched and decoded; an unused command or a refused style goes straight to the
// result, a charge updates the target slot's charge, and a lookup reads the bucket head and
// compares chain entries one by one; a miss then checks for eviction, allocates a slot (from the
// free stack when it holds one) and inserts. Each eviction adds a check, a bucket scan and a walk
// of one chain to its tail. A flush runs the clearing pass. One beat is handled at a time, the
// next once the result is loaded. Reset (asynchronous, active low) runs a clearing pass first.
module glyph_cache_bucket_clock_evict_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // codepoint, style, target_slot, charge_bytes
	input  logic [1:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // found, inserted, refused, slot_index, face_used, evicted_count
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gcbce_pkg::*;

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [3:0]  faces_q;
	logic [31:0] budget_q;
	logic [29:0] out_data;

	// Register file write side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faces_q  <= FACES_RST;
			budget_q <= BUDGET_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_FACES) begin
				faces_q <= pwdata[3:0];
			end else begin
				budget_q <= pwdata;
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUDGET) ? budget_q : {28'd0, faces_q};

	gcbce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gcbce_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_command      (s_tuser),
		.in_codepoint    (s_tdata[31:0]),
		.in_style        (s_tdata[33:32]),
		.in_target_slot  (s_tdata[45:34]),
		.in_charge_bytes (s_tdata[65:46]),
		.faces_present   (faces_q),
		.byte_budget     (budget_q),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_data        (out_data)
	);

	assign m_tdata = {2'd0, out_data};

	// A result never reports both a hit and a new slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("hit and insert in one result");

	// A refused lookup neither hits nor inserts.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (!m_tdata[0] && !m_tdata[1]))
		else $error("refused result carries hit or insert");

	// An accepted beat starts work, so the input side closes next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while busy");

endmodule

FILE: src/gcbce_ctrl.sv
module gcbce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  gcbce_pkg::dp_stat_t stat,
	output gcbce_pkg::dp_cmd_t  cmd
);
	import gcbce_pkg::*;

	typedef enum logic [12:0] {
		ST_CLEAR    = 13'b0000000000001,
		ST_IDLE     = 13'b0000000000010,
		ST_DECODE   = 13'b0000000000100,
		ST_HEAD     = 13'b0000000001000,
		ST_CMP      = 13'b0000000010000,
		ST_EVCHK    = 13'b0000000100000,
		ST_EVSCAN   = 13'b0000001000000,
		ST_EVWALK   = 13'b0000010000000,
		ST_ALLOC    = 13'b0000100000000,
		ST_ALLOC_RD = 13'b0001000000000,
		ST_INSERT   = 13'b0010000000000,
		ST_CHG      = 13'b0100000000000,
		ST_DONE     = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   flush_q, flush_d;

	// Next state and the operation for this cycle.
	always_comb begin
		state_d = state_q;
		flush_d = flush_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last) begin
					state_d = flush_q ? ST_DONE : ST_IDLE;
					flush_d = 1'b0;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LATCH;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.op = OP_DECODE;
				case (stat.cmd)
					CMD_LOOKUP: state_d = stat.face_refused ? ST_DONE : ST_HEAD;
					CMD_CHARGE: state_d = ST_CHG;
					CMD_FLUSH: begin
						state_d = ST_CLEAR;
						flush_d = 1'b1;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_HEAD: begin
				cmd.op  = OP_HEAD;
				state_d = stat.head_empty ? ST_EVCHK : ST_CMP;
			end
			ST_CMP: begin
				cmd.op = OP_CMP;
				if (stat.hit) begin
					state_d = ST_DONE;
				end else if (stat.next_nil) begin
					state_d = ST_EVCHK;
				end
			end
			ST_EVCHK: begin
				cmd.op  = OP_EVCHK;
				state_d = stat.ev_need ? ST_EVSCAN : ST_ALLOC;
			end
			ST_EVSCAN: begin
				cmd.op = OP_EVSCAN;
				if (!stat.scan_empty) begin
					state_d = ST_EVWALK;
				end else if (stat.scan_last) begin
					state_d = ST_ALLOC;
				end
			end
			ST_EVWALK: begin
				cmd.op = OP_EVWALK;
				if (stat.next_nil) begin
					state_d = ST_EVCHK;
				end
			end
			ST_ALLOC: begin
				cmd.op = OP_ALLOC;
				if (!stat.full && stat.free_avail) begin
					state_d = ST_ALLOC_RD;
				end else if (!stat.full && stat.fresh_avail) begin
					state_d = ST_INSERT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ALLOC_RD: begin
				cmd.op  = OP_ALLOC_RD;
				state_d = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.op  = OP_INSERT;
				state_d = ST_DONE;
			end
			ST_CHG: begin
				cmd.op  = OP_CHARGE;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_LOAD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	// State register; reset starts with the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flush_q <= flush_d;
		end
	end

endmodule

FILE: src/gcbce_dp.sv
module gcbce_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  gcbce_pkg::dp_cmd_t  cmd,
	output gcbce_pkg::dp_stat_t stat,
	input  logic [1:0]          in_command,
	input  logic [31:0]         in_codepoint,
	input  logic [1:0]          in_style,
	input  logic [11:0]         in_target_slot,
	input  logic [19:0]         in_charge_bytes,
	input  logic [3:0]          faces_present,
	input  logic [31:0]         byte_budget,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [29:0]         out_data
);
	import gcbce_pkg::*;

	// Latched request.
	logic [1:0]  cmd_q;
	logic [31:0] cp_q;
	logic [1:0]  style_q;
	logic [11:0] tslot_q;
	logic [19:0] mbytes_q;
	logic [1:0]  face_q;
	logic [BW-1:0] hash_q;

	// Walk and eviction registers.
	logic [NW-1:0] cur_q, prev_q, slot_new_q, evicted_q;
	logic [BW-1:0] bkt_q, scan_cnt_q, cursor_q;
	logic [NW-1:0] free_top_q, fresh_q, entry_q;
	logic [31:0]   total_q;
	logic [CW-1:0] clr_q;

	// Result fields.
	logic          res_found_q, res_ins_q, res_ref_q, out_valid_q;
	logic [SW-1:0] res_slot_q;
	logic [1:0]    res_face_q;
	logic [29:0]   out_data_q;

	// Memories.
	logic [NW-1:0] head_mem [BUCKETS];
	logic [NW-1:0] next_mem [MAX_ENTRIES];
	logic [31:0]   code_mem [MAX_ENTRIES];
	logic [1:0]    face_mem [MAX_ENTRIES];
	logic [23:0]   chg_mem  [MAX_ENTRIES];
	logic          live_mem [MAX_ENTRIES];
	logic [SW-1:0] free_mem [MAX_ENTRIES];

	logic [NW-1:0] head_rd, next_rd;
	logic [31:0]   code_rd;
	logic [1:0]    face_rd;
	logic [23:0]   chg_rd;
	logic          live_rd;
	logic [SW-1:0] free_rd;

	logic [BW-1:0] head_raddr, head_waddr;
	logic [NW-1:0] head_wdata;
	logic          head_we;
	logic [SW-1:0] slot_raddr, next_waddr, chg_waddr, live_waddr;
	logic [NW-1:0] next_wdata;
	logic [23:0]   chg_wdata;
	logic          next_we, chg_we, live_we, live_wdata, ins_we, free_we;
	logic [SW-1:0] free_raddr;

	// Face resolution and hash of the latched key.
	logic [1:0]    face_c;
	logic          refused_c;
	logic [31:0]   mix_sum;
	logic [2*BW-1:0] hash_prod;
	logic [BW-1:0] hash_c;
	logic          tail;
	logic [23:0]   room, add24;
	logic [31:0]   add32, chg32;

	always_comb begin
		if (faces_present[style_q]) begin
			face_c = style_q;
		end else if (style_q[0] && faces_present[1]) begin
			face_c = 2'd1;
		end else if (style_q[1] && faces_present[2]) begin
			face_c = 2'd2;
		end else begin
			face_c = 2'd0;
		end
		refused_c = !faces_present[face_c];
		mix_sum   = cp_q + 32'(HASH_MIX * 32'(face_c));
		hash_prod = mix_sum[BW-1:0] * HASH_MUL[BW-1:0];
		hash_c    = hash_prod[BW-1:0];
	end

	// Charge arithmetic with saturation.
	always_comb begin
		room  = CHARGE_MAX - chg_rd;
		add24 = ({4'd0, mbytes_q} > room) ? room : {4'd0, mbytes_q};
		add32 = {8'd0, add24};
		chg32 = {8'd0, chg_rd};
	end

	assign tail = (next_rd >= NIL);

	// Status toward the controller.
	always_comb begin
		stat.clr_last     = (clr_q == CW'(CLR_N - 1));
		stat.cmd          = cmd_q;
		stat.face_refused = refused_c;
		stat.head_empty   = (head_rd >= NIL);
		stat.hit          = (code_rd == cp_q) && (face_rd == face_q);
		stat.next_nil     = tail;
		stat.ev_need      = (entry_q != '0) &&
		                    ((entry_q >= NIL) || (total_q > byte_budget));
		stat.scan_empty   = (head_rd >= NIL);
		stat.scan_last    = (scan_cnt_q == BW'(BUCKETS - 1));
		stat.full         = (entry_q >= NIL);
		stat.free_avail   = (free_top_q != '0);
		stat.fresh_avail  = (fresh_q < NIL);
		stat.out_busy     = out_valid_q && !out_ready;
	end

	// Read addresses.
	always_comb begin
		head_raddr = hash_q;
		slot_raddr = cur_q[SW-1:0];
		case (cmd.op)
			OP_DECODE: begin
				head_raddr = hash_c;
				slot_raddr = SW'(tslot_q);
			end
			OP_HEAD:   slot_raddr = head_rd[SW-1:0];
			OP_CMP:    slot_raddr = next_rd[SW-1:0];
			OP_EVCHK:  head_raddr = cursor_q;
			OP_EVSCAN: begin
				head_raddr = bkt_q + 1'b1;
				slot_raddr = head_rd[SW-1:0];
			end
			OP_EVWALK: slot_raddr = next_rd[SW-1:0];
			default: ;
		endcase
		free_raddr = SW'(free_top_q - 1'b1);
	end

	// Write ports.
	always_comb begin
		head_we    = 1'b0;
		head_waddr = hash_q;
		head_wdata = slot_new_q;
		next_we    = 1'b0;
		next_waddr = slot_new_q[SW-1:0];
		next_wdata = head_rd;
		chg_we     = 1'b0;
		chg_waddr  = slot_new_q[SW-1:0];
		chg_wdata  = '0;
		live_we    = 1'b0;
		live_waddr = slot_new_q[SW-1:0];
		live_wdata = 1'b1;
		ins_we     = 1'b0;
		free_we    = 1'b0;
		case (cmd.op)
			OP_CLEAR: begin
				head_we    = (32'(clr_q) < BUCKETS);
				head_waddr = clr_q[BW-1:0];
				head_wdata = NIL;
				live_we    = (32'(clr_q) < MAX_ENTRIES);
				live_waddr = clr_q[SW-1:0];
				live_wdata = 1'b0;
			end
			OP_EVWALK: begin
				if (tail) begin
					head_we    = (prev_q == NIL);
					head_waddr = bkt_q;
					head_wdata = NIL;
					next_we    = (prev_q != NIL);
					next_waddr = prev_q[SW-1:0];
					next_wdata = NIL;
					chg_we     = 1'b1;
					chg_waddr  = cur_q[SW-1:0];
					live_we    = 1'b1;
					live_waddr = cur_q[SW-1:0];
					live_wdata = 1'b0;
					free_we    = (free_top_q < NIL);
				end
			end
			OP_INSERT: begin
				head_we = 1'b1;
				next_we = 1'b1;
				chg_we  = 1'b1;
				live_we = 1'b1;
				ins_we  = 1'b1;
			end
			OP_CHARGE: begin
				chg_we    = live_rd && (32'(tslot_q) < MAX_ENTRIES);
				chg_waddr = SW'(tslot_q);
				chg_wdata = chg_rd + add24;
			end
			default: ;
		endcase
	end

	// Bucket head memory.
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd <= head_mem[head_raddr];
	end

	// Slot memories share one read address.
	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		if (chg_we) begin
			chg_mem[chg_waddr] <= chg_wdata;
		end
		if (live_we) begin
			live_mem[live_waddr] <= live_wdata;
		end
		if (ins_we) begin
			code_mem[slot_new_q[SW-1:0]] <= cp_q;
			face_mem[slot_new_q[SW-1:0]] <= face_q;
		end
		next_rd <= next_mem[slot_raddr];
		code_rd <= code_mem[slot_raddr];
		face_rd <= face_mem[slot_raddr];
		chg_rd  <= chg_mem[slot_raddr];
		live_rd <= live_mem[slot_raddr];
	end

	// Free slot stack.
	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_top_q[SW-1:0]] <= cur_q[SW-1:0];
		end
		free_rd <= free_mem[free_raddr];
	end

	// Request and walk registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				cmd_q    <= in_command;
				cp_q     <= in_codepoint;
				style_q  <= in_style;
				tslot_q  <= in_target_slot;
				mbytes_q <= in_charge_bytes;
			end
			OP_DECODE: begin
				face_q      <= face_c;
				hash_q      <= hash_c;
				evicted_q   <= '0;
				res_found_q <= 1'b0;
				res_ins_q   <= 1'b0;
				res_slot_q  <= '0;
				res_face_q  <= (cmd_q == CMD_LOOKUP) ? face_c : 2'd0;
				res_ref_q   <= (cmd_q == CMD_LOOKUP) && refused_c;
			end
			OP_HEAD: cur_q <= head_rd;
			OP_CMP: begin
				if (stat.hit) begin
					res_found_q <= 1'b1;
					res_slot_q  <= cur_q[SW-1:0];
				end
				cur_q <= next_rd;
			end
			OP_EVCHK: begin
				bkt_q      <= cursor_q;
				scan_cnt_q <= '0;
			end
			OP_EVSCAN: begin
				if (head_rd >= NIL) begin
					bkt_q      <= bkt_q + 1'b1;
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end else begin
					cur_q  <= head_rd;
					prev_q <= NIL;
				end
			end
			OP_EVWALK: begin
				if (!tail) begin
					prev_q <= cur_q;
					cur_q  <= next_rd;
				end else begin
					evicted_q <= evicted_q + 1'b1;
				end
			end
			OP_ALLOC: begin
				if (stat.full || (!stat.free_avail && !stat.fresh_avail)) begin
					res_ref_q <= 1'b1;
				end else if (!stat.free_avail) begin
					slot_new_q <= fresh_q;
				end
			end
			OP_ALLOC_RD: slot_new_q <= {1'b0, free_rd};
			OP_INSERT: begin
				res_ins_q  <= 1'b1;
				res_slot_q <= slot_new_q[SW-1:0];
			end
			default: ;
		endcase
	end

	// Counters and the result beat register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q  <= '0;
			fresh_q     <= '0;
			entry_q     <= '0;
			total_q     <= '0;
			cursor_q    <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_CLEAR: clr_q <= stat.clr_last ? '0 : clr_q + 1'b1;
				OP_DECODE: begin
					if (cmd_q == CMD_FLUSH) begin
						free_top_q <= '0;
						fresh_q    <= '0;
						entry_q    <= '0;
						total_q    <= '0;
						cursor_q   <= '0;
						clr_q      <= '0;
					end
				end
				OP_EVWALK: begin
					if (tail) begin
						total_q  <= (total_q > chg32) ? total_q - chg32 : 32'd0;
						cursor_q <= bkt_q + 1'b1;
						if (free_top_q < NIL) begin
							free_top_q <= free_top_q + 1'b1;
						end
						if (entry_q != '0) begin
							entry_q <= entry_q - 1'b1;
						end
					end
				end
				OP_ALLOC: begin
					if (!stat.full && stat.free_avail) begin
						free_top_q <= free_top_q - 1'b1;
					end else if (!stat.full && stat.fresh_avail) begin
						fresh_q <= fresh_q + 1'b1;
					end
				end
				OP_INSERT: entry_q <= entry_q + 1'b1;
				OP_CHARGE: begin
					if (live_rd && (32'(tslot_q) < MAX_ENTRIES)) begin
						total_q <= (total_q > (32'hFFFFFFFF - add32)) ?
						           32'hFFFFFFFF : total_q + add32;
					end
				end
				OP_LOAD_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Result payload, loaded with the beat.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD_OUT) begin
			out_data_q <= {13'(evicted_q), res_face_q, 12'(res_slot_q),
			               res_ref_q, res_ins_q, res_found_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
